// File: rtl/box_region_relation_merge_assert.svh
`ifndef BOX_REGION_RELATION_MERGE_ASSERT_SVH
`define BOX_REGION_RELATION_MERGE_ASSERT_SVH

// condition checked at every clock edge out of reset
`define BRRM_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("box_region_relation_merge: check failed");

// consequence in the cycle after the trigger
`define BRRM_ASSERT_NEXT(label, trig, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error("box_region_relation_merge: check failed");

`endif

// File: rtl/brrm_pkg.sv
`default_nettype none

package brrm_pkg;

	localparam int NUM_DIMS     = 3;
	localparam int COORD_W      = 48;
	localparam int END_W        = COORD_W + 1;
	localparam int DIM_W        = 2;
	localparam int CFG_W        = 2;
	localparam int DEF_MAX_DIMS = 3;
	localparam logic [CFG_W-1:0] DIMS_RESET = 2'd3;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [END_W-1:0]   end_t;
	typedef logic [DIM_W-1:0]   dim_t;

	typedef enum logic [1:0] {
		REL_A_IN_B   = 2'd0,
		REL_B_IN_A   = 2'd1,
		REL_PARTIAL  = 2'd2,
		REL_DISJOINT = 2'd3
	} rel_t;

	typedef struct packed {
		coord_t [NUM_DIMS-1:0] a_off;
		coord_t [NUM_DIMS-1:0] a_size;
		coord_t [NUM_DIMS-1:0] b_off;
		coord_t [NUM_DIMS-1:0] b_size;
		logic [NUM_DIMS-1:0]   used;
		dim_t                  last_dim;
	} pair_t;

	typedef struct packed {
		coord_t [NUM_DIMS-1:0] a_off;
		coord_t [NUM_DIMS-1:0] a_size;
		coord_t [NUM_DIMS-1:0] b_off;
		coord_t [NUM_DIMS-1:0] b_size;
		end_t [NUM_DIMS-1:0]   a_end;
		end_t [NUM_DIMS-1:0]   b_end;
		logic [NUM_DIMS-1:0]   used;
		dim_t                  last_dim;
	} s1_t;

	typedef struct packed {
		logic [NUM_DIMS-1:0]   a_in_b;
		logic [NUM_DIMS-1:0]   b_in_a;
		logic [NUM_DIMS-1:0]   ovl;
		logic [NUM_DIMS-1:0]   detached;
		logic [NUM_DIMS-1:0]   differs;
		coord_t [NUM_DIMS-1:0] st;
		end_t [NUM_DIMS-1:0]   en;
		coord_t [NUM_DIMS-1:0] lo;
		end_t [NUM_DIMS-1:0]   hi;
		logic [NUM_DIMS-1:0]   used;
		dim_t                  last_dim;
	} s2_t;

	typedef struct packed {
		rel_t                  relation;
		logic                  merge_ok;
		dim_t                  connect_dim;
		coord_t [NUM_DIMS-1:0] ov_off;
		coord_t [NUM_DIMS-1:0] ov_size;
		coord_t [NUM_DIMS-1:0] m_off;
		end_t [NUM_DIMS-1:0]   m_size;
	} s3_t;

endpackage

`default_nettype wire

// File: rtl/brrm_ends.sv
`default_nettype none

module brrm_ends (
	input  wire logic           clk,
	input  wire logic           load,
	input  wire brrm_pkg::pair_t pair,
	output brrm_pkg::s1_t       out_s1
);
	import brrm_pkg::*;

	always_ff @(posedge clk) begin
		if (load) begin
			for (int d = 0; d < NUM_DIMS; d++) begin
				out_s1.a_end[d] <= {1'b0, pair.a_off[d]} + {1'b0, pair.a_size[d]};
				out_s1.b_end[d] <= {1'b0, pair.b_off[d]} + {1'b0, pair.b_size[d]};
			end
			out_s1.a_off    <= pair.a_off;
			out_s1.a_size   <= pair.a_size;
			out_s1.b_off    <= pair.b_off;
			out_s1.b_size   <= pair.b_size;
			out_s1.used     <= pair.used;
			out_s1.last_dim <= pair.last_dim;
		end
	end

endmodule

`default_nettype wire

// File: rtl/brrm_compare.sv
`default_nettype none

module brrm_compare (
	input  wire logic           clk,
	input  wire logic           load,
	input  wire brrm_pkg::s1_t  in_s1,
	output brrm_pkg::s2_t       out_s2
);
	import brrm_pkg::*;

	always_ff @(posedge clk) begin
		if (load) begin
			for (int d = 0; d < NUM_DIMS; d++) begin
				out_s2.a_in_b[d] <= !(in_s1.b_off[d] > in_s1.a_off[d]) &&
					!(in_s1.b_end[d] < in_s1.a_end[d]);
				out_s2.b_in_a[d] <= !(in_s1.a_off[d] > in_s1.b_off[d]) &&
					!(in_s1.a_end[d] < in_s1.b_end[d]);
				out_s2.ovl[d] <= !(in_s1.b_end[d] <= {1'b0, in_s1.a_off[d]}) &&
					!({1'b0, in_s1.b_off[d]} >= in_s1.a_end[d]);
				out_s2.detached[d] <= ({1'b0, in_s1.a_off[d]} > in_s1.b_end[d]) ||
					({1'b0, in_s1.b_off[d]} > in_s1.a_end[d]);
				out_s2.differs[d] <= (in_s1.a_off[d] != in_s1.b_off[d]) ||
					(in_s1.a_size[d] != in_s1.b_size[d]);
				out_s2.st[d] <= (in_s1.a_off[d] > in_s1.b_off[d]) ?
					in_s1.a_off[d] : in_s1.b_off[d];
				out_s2.lo[d] <= (in_s1.a_off[d] < in_s1.b_off[d]) ?
					in_s1.a_off[d] : in_s1.b_off[d];
				out_s2.en[d] <= (in_s1.a_end[d] < in_s1.b_end[d]) ?
					in_s1.a_end[d] : in_s1.b_end[d];
				out_s2.hi[d] <= (in_s1.a_end[d] > in_s1.b_end[d]) ?
					in_s1.a_end[d] : in_s1.b_end[d];
			end
			out_s2.used     <= in_s1.used;
			out_s2.last_dim <= in_s1.last_dim;
		end
	end

endmodule

`default_nettype wire

// File: rtl/brrm_reduce.sv
`default_nettype none

module brrm_reduce (
	input  wire logic           clk,
	input  wire logic           load,
	input  wire brrm_pkg::s2_t  in_s2,
	output brrm_pkg::s3_t       out_s3
);
	import brrm_pkg::*;

	logic                  all_a_in_b;
	logic                  all_b_in_a;
	logic                  all_ovl;
	logic                  any_det;
	logic [NUM_DIMS-1:0]   dif;
	logic                  merge;
	rel_t                  rel;
	dim_t                  cdim;
	coord_t [NUM_DIMS-1:0] ov_off;
	coord_t [NUM_DIMS-1:0] ov_size;
	end_t [NUM_DIMS-1:0]   m_size;

	always_comb begin
		all_a_in_b = &(in_s2.a_in_b | ~in_s2.used);
		all_b_in_a = &(in_s2.b_in_a | ~in_s2.used);
		all_ovl    = &(in_s2.ovl | ~in_s2.used);
		any_det    = |(in_s2.detached & in_s2.used);
		dif        = in_s2.differs & in_s2.used;
		merge      = !any_det && ((dif & (dif - 1'b1)) == '0);

		priority if (all_a_in_b) begin
			rel = REL_A_IN_B;
		end else if (all_b_in_a) begin
			rel = REL_B_IN_A;
		end else if (all_ovl) begin
			rel = REL_PARTIAL;
		end else begin
			rel = REL_DISJOINT;
		end

		// first differing dimension, else the last one in use; zero when the boxes do not merge
		cdim = in_s2.last_dim;
		for (int d = NUM_DIMS - 1; d >= 0; d--) begin
			if (dif[d]) begin
				cdim = DIM_W'(d);
			end
		end
		if (!merge) begin
			cdim = '0;
		end

		for (int d = 0; d < NUM_DIMS; d++) begin
			if (in_s2.used[d] && (rel != REL_DISJOINT)) begin
				ov_off[d] = in_s2.st[d];
				ov_size[d] = (in_s2.en[d] > {1'b0, in_s2.st[d]}) ?
					COORD_W'(in_s2.en[d] - {1'b0, in_s2.st[d]}) : '0;
			end else begin
				ov_off[d]  = '0;
				ov_size[d] = '0;
			end
			m_size[d] = in_s2.hi[d] - {1'b0, in_s2.lo[d]};
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_s3.relation    <= rel;
			out_s3.merge_ok    <= merge;
			out_s3.connect_dim <= cdim;
			out_s3.ov_off      <= ov_off;
			out_s3.ov_size     <= ov_size;
			out_s3.m_off       <= in_s2.lo;
			out_s3.m_size      <= m_size;
		end
	end

endmodule

`default_nettype wire

// File: rtl/box_region_relation_merge.sv
`default_nettype none

// Compares two axis-aligned boxes A and B (offset and size per dimension, 48-bit
// unsigned) over the first dims_in_use dimensions and returns their containment
// relation, the intersection box, whether they merge into one box, and the merge
// dimension with the merged offset and extent. One box pair is accepted per
// cycle while in_stall is low and passes the ends, per-dimension compare,
// reduction and output registers. Each stage holds its item only while the
// stage after it is full and stalled, so empty stages fill up behind a stalled
// output. dims_in_use is written through the cfg channel, which is always ready;
// 0 acts as 1 and values above MAX_DIMS act as MAX_DIMS.
module box_region_relation_merge #(
	parameter int MAX_DIMS = brrm_pkg::DEF_MAX_DIMS
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,

	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [brrm_pkg::CFG_W-1:0] cfg_data,

	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire brrm_pkg::coord_t         a_offset_0,
	input  wire brrm_pkg::coord_t         a_offset_1,
	input  wire brrm_pkg::coord_t         a_offset_2,
	input  wire brrm_pkg::coord_t         a_size_0,
	input  wire brrm_pkg::coord_t         a_size_1,
	input  wire brrm_pkg::coord_t         a_size_2,
	input  wire brrm_pkg::coord_t         b_offset_0,
	input  wire brrm_pkg::coord_t         b_offset_1,
	input  wire brrm_pkg::coord_t         b_offset_2,
	input  wire brrm_pkg::coord_t         b_size_0,
	input  wire brrm_pkg::coord_t         b_size_1,
	input  wire brrm_pkg::coord_t         b_size_2,

	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [1:0]                    relation,
	output logic                          merge_ok,
	output brrm_pkg::dim_t                connect_dim,
	output brrm_pkg::coord_t              merged_offset,
	output brrm_pkg::end_t                merged_size,
	output brrm_pkg::coord_t              overlap_offset_0,
	output brrm_pkg::coord_t              overlap_offset_1,
	output brrm_pkg::coord_t              overlap_offset_2,
	output brrm_pkg::coord_t              overlap_size_0,
	output brrm_pkg::coord_t              overlap_size_1,
	output brrm_pkg::coord_t              overlap_size_2
);
	import brrm_pkg::*;

	`include "box_region_relation_merge_assert.svh"

	logic [CFG_W-1:0] dims_q;
	dim_t             n_dims;
	pair_t            pair;
	s1_t              stage_s1;
	s2_t              stage_s2;
	s3_t              stage_s3;
	logic             valid_s1;
	logic             valid_s2;
	logic             valid_s3;
	logic             load_s1;
	logic             load_s2;
	logic             load_s3;
	logic             load_s4;
	logic             refused_clear;
	logic             disjoint_clear;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= DIMS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			dims_q <= cfg_data;
		end
	end

	always_comb begin
		n_dims = DIM_W'(dims_q);
		if (n_dims == '0) begin
			n_dims = DIM_W'(1);
		end
		if (int'(n_dims) > MAX_DIMS) begin
			n_dims = DIM_W'(MAX_DIMS);
		end

		pair.a_off    = {a_offset_2, a_offset_1, a_offset_0};
		pair.a_size   = {a_size_2, a_size_1, a_size_0};
		pair.b_off    = {b_offset_2, b_offset_1, b_offset_0};
		pair.b_size   = {b_size_2, b_size_1, b_size_0};
		pair.last_dim = n_dims - DIM_W'(1);
		for (int d = 0; d < NUM_DIMS; d++) begin
			pair.used[d] = (DIM_W'(d) < n_dims);
		end
	end

	// a stage takes a new item when empty or when the next stage takes its item
	assign load_s4  = !out_valid || !out_stall;
	assign load_s3  = !valid_s3 || load_s4;
	assign load_s2  = !valid_s2 || load_s3;
	assign load_s1  = !valid_s1 || load_s2;
	assign in_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= in_valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
			if (load_s3) begin
				valid_s3 <= valid_s2;
			end
			if (load_s4) begin
				out_valid <= valid_s3;
			end
		end
	end

	brrm_ends u_ends (
		.clk    (clk),
		.load   (load_s1),
		.pair   (pair),
		.out_s1 (stage_s1)
	);

	brrm_compare u_compare (
		.clk    (clk),
		.load   (load_s2),
		.in_s1  (stage_s1),
		.out_s2 (stage_s2)
	);

	brrm_reduce u_reduce (
		.clk    (clk),
		.load   (load_s3),
		.in_s2  (stage_s2),
		.out_s3 (stage_s3)
	);

	// output register: pick the merged offset and size at the merge dimension
	always_ff @(posedge clk) begin
		if (load_s4) begin
			relation         <= stage_s3.relation;
			merge_ok         <= stage_s3.merge_ok;
			connect_dim      <= stage_s3.connect_dim;
			merged_offset    <= stage_s3.merge_ok ?
				stage_s3.m_off[stage_s3.connect_dim] : '0;
			merged_size      <= stage_s3.merge_ok ?
				stage_s3.m_size[stage_s3.connect_dim] : '0;
			overlap_offset_0 <= stage_s3.ov_off[0];
			overlap_offset_1 <= stage_s3.ov_off[1];
			overlap_offset_2 <= stage_s3.ov_off[2];
			overlap_size_0   <= stage_s3.ov_size[0];
			overlap_size_1   <= stage_s3.ov_size[1];
			overlap_size_2   <= stage_s3.ov_size[2];
		end
	end

	assign refused_clear = (connect_dim == '0) && (merged_offset == '0) &&
		(merged_size == '0);
	assign disjoint_clear = (overlap_offset_0 == '0) && (overlap_size_0 == '0) &&
		(overlap_offset_1 == '0) && (overlap_size_1 == '0) &&
		(overlap_offset_2 == '0) && (overlap_size_2 == '0);

	`BRRM_ASSERT_ALWAYS(a_refused_zero, !out_valid || merge_ok || refused_clear)
	`BRRM_ASSERT_ALWAYS(a_disjoint_zero, !out_valid || (relation != REL_DISJOINT) || disjoint_clear)
	`BRRM_ASSERT_ALWAYS(a_dim_range, !out_valid || (int'(connect_dim) < MAX_DIMS))
	`BRRM_ASSERT_NEXT(a_s3_moves, valid_s3 && load_s4, out_valid)

endmodule

`default_nettype wire

// File: bench/box_region_relation_merge_test.sv
module box_region_relation_merge_test;
	import brrm_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 60;
	localparam int SETTLE_CYCLES = 8;
	localparam coord_t COORD_MAX = '1;

	typedef struct packed {
		coord_t [NUM_DIMS-1:0] a_off, a_size, b_off, b_size;
	} box_pair_t;

	typedef struct packed {
		rel_t                  rel;
		logic                  merge;
		dim_t                  cdim;
		coord_t                m_off;
		end_t                  m_size;
		coord_t [NUM_DIMS-1:0] ov_off, ov_size;
	} box_result_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data;
	logic             in_valid;
	logic             in_stall;
	box_pair_t        in_pair;
	logic             out_valid;
	logic             out_stall;
	logic [1:0]       relation;
	logic             merge_ok;
	dim_t             connect_dim;
	coord_t           merged_offset;
	end_t             merged_size;
	coord_t           overlap_offset_0, overlap_offset_1, overlap_offset_2;
	coord_t           overlap_size_0, overlap_size_1, overlap_size_2;

	box_result_t      pending_results[$];
	box_result_t      seen;
	box_result_t      want;
	logic [CFG_W-1:0] dims_setting = DIMS_RESET;
	int unsigned      fault_count = 0;
	int unsigned      cycle_count = 0;
	bit               send_bursts;
	bit               stall_bursts;
	bit               hold_request = 1'b0;
	bit               hold_active = 1'b0;

	box_region_relation_merge i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.a_offset_0       (in_pair.a_off[0]),
		.a_offset_1       (in_pair.a_off[1]),
		.a_offset_2       (in_pair.a_off[2]),
		.a_size_0         (in_pair.a_size[0]),
		.a_size_1         (in_pair.a_size[1]),
		.a_size_2         (in_pair.a_size[2]),
		.b_offset_0       (in_pair.b_off[0]),
		.b_offset_1       (in_pair.b_off[1]),
		.b_offset_2       (in_pair.b_off[2]),
		.b_size_0         (in_pair.b_size[0]),
		.b_size_1         (in_pair.b_size[1]),
		.b_size_2         (in_pair.b_size[2]),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.relation         (relation),
		.merge_ok         (merge_ok),
		.connect_dim      (connect_dim),
		.merged_offset    (merged_offset),
		.merged_size      (merged_size),
		.overlap_offset_0 (overlap_offset_0),
		.overlap_offset_1 (overlap_offset_1),
		.overlap_offset_2 (overlap_offset_2),
		.overlap_size_0   (overlap_size_0),
		.overlap_size_1   (overlap_size_1),
		.overlap_size_2   (overlap_size_2)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic box_result_t predict_boxes(box_pair_t p, logic [CFG_W-1:0] dims);
		box_result_t r;
		end_t        a_end [NUM_DIMS];
		end_t        b_end [NUM_DIMS];
		coord_t      st;
		end_t        en;
		int          n;
		int          d;
		int          join_dim;
		bit          a_in_b, b_in_a, ovl, can_merge;
		r = '0;
		n = (dims == 0) ? 1 : int'(dims);
		if (n > NUM_DIMS) n = NUM_DIMS;
		a_in_b = 1'b1;
		b_in_a = 1'b1;
		ovl = 1'b1;
		can_merge = 1'b1;
		join_dim = -1;
		for (d = 0; d < n; d++) begin
			a_end[d] = end_t'(p.a_off[d]) + p.a_size[d];
			b_end[d] = end_t'(p.b_off[d]) + p.b_size[d];
			if (p.b_off[d] > p.a_off[d] || b_end[d] < a_end[d]) a_in_b = 1'b0;
			if (p.a_off[d] > p.b_off[d] || a_end[d] < b_end[d]) b_in_a = 1'b0;
			if (b_end[d] <= p.a_off[d] || p.b_off[d] >= a_end[d]) ovl = 1'b0;
		end
		if (a_in_b) r.rel = REL_A_IN_B;
		else if (b_in_a) r.rel = REL_B_IN_A;
		else if (ovl) r.rel = REL_PARTIAL;
		else r.rel = REL_DISJOINT;
		if (r.rel != REL_DISJOINT) begin
			for (d = 0; d < n; d++) begin
				st = (p.a_off[d] > p.b_off[d]) ? p.a_off[d] : p.b_off[d];
				en = (a_end[d] < b_end[d]) ? a_end[d] : b_end[d];
				r.ov_off[d] = st;
				r.ov_size[d] = (en > st) ? coord_t'(en - st) : '0;
			end
		end
		for (d = 0; d < n && can_merge; d++) begin
			if (p.a_off[d] > b_end[d] || p.b_off[d] > a_end[d]) begin
				can_merge = 1'b0;
			end else if (p.a_off[d] != p.b_off[d] || p.a_size[d] != p.b_size[d]) begin
				if (join_dim < 0) join_dim = d;
				else can_merge = 1'b0;
			end
		end
		if (can_merge) begin
			if (join_dim < 0) join_dim = n - 1;
			r.merge = 1'b1;
			r.cdim = dim_t'(join_dim);
			r.m_off = (p.a_off[join_dim] < p.b_off[join_dim]) ? p.a_off[join_dim]
				: p.b_off[join_dim];
			en = (a_end[join_dim] > b_end[join_dim]) ? a_end[join_dim] : b_end[join_dim];
			r.m_size = en - r.m_off;
		end
		return r;
	endfunction

	function automatic coord_t rand48();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[COORD_W-1:0];
	endfunction

	function automatic coord_t small_val();
		return coord_t'($urandom_range(0, 15));
	endfunction

	function automatic box_pair_t uniform_pair(coord_t ao, coord_t as, coord_t bo, coord_t bs);
		box_pair_t p;
		int        d;
		for (d = 0; d < NUM_DIMS; d++) begin
			p.a_off[d] = ao;
			p.a_size[d] = as;
			p.b_off[d] = bo;
			p.b_size[d] = bs;
		end
		return p;
	endfunction

	// dimensions from first upward are left out of the comparison
	function automatic box_pair_t scramble_upper(box_pair_t p, int first);
		int d;
		for (d = first; d < NUM_DIMS; d++) begin
			p.a_off[d] = rand48();
			p.a_size[d] = rand48();
			p.b_off[d] = rand48();
			p.b_size[d] = rand48();
		end
		return p;
	endfunction

	function automatic box_pair_t random_pair();
		box_pair_t   p;
		coord_t      base;
		int unsigned style;
		int          d;
		int          k;
		style = $urandom_range(0, 9);
		base = (style == 3) ? COORD_MAX - 40 : rand48();
		for (d = 0; d < NUM_DIMS; d++) begin
			if (style == 0) begin
				p.a_off[d] = rand48();
				p.a_size[d] = rand48();
				p.b_off[d] = rand48();
				p.b_size[d] = rand48();
			end else if (style == 1) begin
				p.a_off[d] = small_val();
				p.a_size[d] = rand48();
				p.b_off[d] = small_val();
				p.b_size[d] = rand48();
			end else begin
				p.a_off[d] = base + small_val();
				p.a_size[d] = small_val();
				if (style >= 5) begin
					p.b_off[d] = p.a_off[d];
					p.b_size[d] = p.a_size[d];
				end else begin
					p.b_off[d] = base + small_val();
					p.b_size[d] = small_val();
				end
			end
		end
		// boxes equal but for at most one dimension (two for style 9)
		if (style >= 5) begin
			k = $urandom_range(0, NUM_DIMS - 1);
			case ($urandom_range(0, 5))
				0: p.b_off[k] = p.a_off[k] + p.a_size[k];
				1: p.b_off[k] = p.a_off[k] + p.a_size[k] + 1;
				2: p.b_off[k] = p.a_off[k] + small_val();
				3: begin
					p.b_size[k] = small_val();
					p.b_off[k] = p.a_off[k] - p.b_size[k];
				end
				4: p.b_size[k] = small_val();
				default: ;
			endcase
			if (style == 9) begin
				k = (k + 1) % NUM_DIMS;
				p.b_size[k] = p.a_size[k] + 1;
			end
		end
		return p;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] wanted);
		fault_count++;
		$display("mismatch %s: got %0h want %0h", what, got, wanted);
	endtask

	always_comb begin
		seen.rel = rel_t'(relation);
		seen.merge = merge_ok;
		seen.cdim = connect_dim;
		seen.m_off = merged_offset;
		seen.m_size = merged_size;
		seen.ov_off = {overlap_offset_2, overlap_offset_1, overlap_offset_0};
		seen.ov_size = {overlap_size_2, overlap_size_1, overlap_size_0};
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing expected", 0, 0);
			end else begin
				want = pending_results.pop_front();
				if (seen.rel !== want.rel) report_mismatch("relation", seen.rel, want.rel);
				if (seen.merge !== want.merge) report_mismatch("merge_ok", seen.merge, want.merge);
				if (seen.cdim !== want.cdim) report_mismatch("connect_dim", seen.cdim, want.cdim);
				if (seen.m_off !== want.m_off)
					report_mismatch("merged_offset", seen.m_off, want.m_off);
				if (seen.m_size !== want.m_size)
					report_mismatch("merged_size", seen.m_size, want.m_size);
				for (int d = 0; d < NUM_DIMS; d++) begin
					if (seen.ov_off[d] !== want.ov_off[d])
						report_mismatch($sformatf("overlap_offset_%0d", d),
							seen.ov_off[d], want.ov_off[d]);
					if (seen.ov_size[d] !== want.ov_size[d])
						report_mismatch($sformatf("overlap_size_%0d", d),
							seen.ov_size[d], want.ov_size[d]);
				end
			end
		end
	end

	// receiver: random stall bursts, or one long hold on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_stall <= 1'b1;
				hold_active = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
				hold_active = 1'b0;
			end else if (stall_bursts && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(0, 16)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_pair(box_pair_t p);
		if (send_bursts && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_pair <= p;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(predict_boxes(p, dims_setting));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_dims(logic [CFG_W-1:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		dims_setting = value;
	endtask

	task automatic test_relations();
		box_pair_t p;
		send_pair(uniform_pair(100, 50, 100, 50));
		send_pair(uniform_pair(110, 10, 100, 50));
		send_pair(uniform_pair(100, 50, 110, 10));
		send_pair(uniform_pair(100, 50, 120, 50));
		send_pair(uniform_pair(0, 10, 100, 10));
		p = uniform_pair(0, 10, 0, 10);
		p.b_off[0] = 10;
		send_pair(p);
		send_pair(uniform_pair(5, 0, 5, 0));
		send_pair(uniform_pair(0, 0, 0, 0));
		send_pair(uniform_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
		send_pair(uniform_pair(COORD_MAX, COORD_MAX, 0, COORD_MAX));
		wait_drained();
	endtask

	task automatic test_merge();
		box_pair_t p;
		p = uniform_pair(200, 30, 200, 30);
		p.b_off[1] = 220;
		send_pair(p);
		p = uniform_pair(200, 30, 200, 30);
		p.b_off[0] = 210;
		p.b_size[2] = 5;
		send_pair(p);
		p = uniform_pair(200, 30, 200, 30);
		p.b_off[2] = 231;
		send_pair(p);
		p = uniform_pair(200, 30, 200, 30);
		p.b_off[1] = 180;
		p.b_size[1] = 20;
		send_pair(p);
		p = uniform_pair(200, 30, 200, 30);
		p.b_size[0] = 60;
		send_pair(p);
		wait_drained();
	endtask

	task automatic test_single_dim();
		box_pair_t p;
		write_dims(2'd1);
		send_pair(scramble_upper(uniform_pair(300, 40, 300, 40), 1));
		send_pair(scramble_upper(uniform_pair(300, 40, 320, 40), 1));
		p = uniform_pair(300, 40, 310, 10);
		p.b_off[1] = 0;
		p.b_off[2] = COORD_MAX;
		send_pair(p);
	endtask

	task automatic test_dims_zero();
		write_dims(2'd0);
		send_pair(scramble_upper(uniform_pair(500, 8, 504, 8), 1));
		send_pair(scramble_upper(uniform_pair(500, 8, 508, 8), 1));
	endtask

	task automatic test_two_dims();
		write_dims(2'd2);
		send_pair(scramble_upper(uniform_pair(700, 16, 700, 16), 2));
		send_pair(scramble_upper(uniform_pair(700, 16, 690, 4), 2));
	endtask

	// receiver holds off while the sender keeps offering, so the pipe backs up
	task automatic test_backpressure();
		write_dims(2'd3);
		send_bursts = 1'b0;
		hold_request = 1'b1;
		wait (hold_active);
		repeat (24) send_pair(random_pair());
		send_bursts = 1'b1;
		wait_drained();
	endtask

	task automatic test_random(logic [CFG_W-1:0] dims, int count);
		write_dims(dims);
		repeat (count) send_pair(random_pair());
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_pair = '0;
		send_bursts = 1'b1;
		stall_bursts = 1'b1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_relations();
		test_merge();
		test_single_dim();
		test_dims_zero();
		test_two_dims();
		test_backpressure();
		test_random(2'd2, 350);
		test_random(2'd1, 300);
		test_random(2'd0, 150);
		test_random(2'd3, 500);
		send_bursts = 1'b0;
		stall_bursts = 1'b0;
		test_random(2'd3, 500);
		wait_drained();
		if (fault_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/brrm_pkg.sv
rtl/brrm_ends.sv
rtl/brrm_compare.sv
rtl/brrm_reduce.sv
rtl/box_region_relation_merge.sv
bench/box_region_relation_merge_test.sv
